// ===== rtl/core/rlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpm_pkg
// Shared types, codes and helpers of the longest prefix match route engine.
// ----------------------------------------------------------------------------
package rlpm_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int CELL_ADDR_W     = 5;
	localparam int CELL_DEPTH      = 1 << CELL_ADDR_W;
	localparam int LEN_W           = 6;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [2:0] STAT_HIT     = 3'd0;
	localparam logic [2:0] STAT_MISS    = 3'd1;
	localparam logic [2:0] STAT_LOADED  = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_CLEARED = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] lookup_address;
		logic [31:0] route_prefix;
		logic [31:0] route_mask;
		logic [31:0] route_gateway;
		logic [3:0]  route_port;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] gateway;
		logic [3:0]  out_port;
		logic [31:0] match_mask;
	} rsp_t;

	typedef struct packed {
		logic [31:0]      prefix;
		logic [31:0]      mask;
		logic [31:0]      hop;
		logic [3:0]       port;
		logic [LEN_W-1:0] len;
	} entry_t;

	typedef struct packed {
		logic             found;
		logic [LEN_W-1:0] len;
		logic [31:0]      hop;
		logic [3:0]       port;
		logic [31:0]      mask;
	} cand_t;

	typedef struct packed {
		logic                   wr_en;
		logic                   rd_en;
		logic [CELL_ADDR_W-1:0] rd_row;
		logic                   acc_clr;
		logic                   reduce;
	} ctl_t;

	function automatic logic [LEN_W-1:0] mask_len(input logic [31:0] m);
		logic [3:0]       byte_cnt [4];
		logic [LEN_W-1:0] total;
		total = '0;
		for (int b = 0; b < 4; b++) begin
			byte_cnt[b] = '0;
			for (int i = 0; i < 8; i++) begin
				byte_cnt[b] = byte_cnt[b] + 4'(m[8*b+i]);
			end
		end
		for (int b = 0; b < 4; b++) begin
			total = total + LEN_W'(byte_cnt[b]);
		end
		return total;
	endfunction

endpackage

// ===== rtl/core/rlpm_ram.sv =====
// ----------------------------------------------------------------------------
// rlpm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rlpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/rlpm_cell.sv =====
// ----------------------------------------------------------------------------
// rlpm_cell
// One cell of the route chain: a slice of the table, a scan that keeps the
// best local match, and a merge with the best route handed in from the left.
// ----------------------------------------------------------------------------
module rlpm_cell #(
	parameter int CNT_W    = 11,
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rlpm_pkg::ctl_t      ctl,
	input  logic [CNT_W-1:0]    wr_idx,
	input  rlpm_pkg::entry_t    wr_entry,
	input  logic [CNT_W-1:0]    count,
	input  logic [31:0]         addr,
	input  rlpm_pkg::cand_t     left,
	output rlpm_pkg::cand_t     best
);

	localparam int CAW = rlpm_pkg::CELL_ADDR_W;
	localparam logic [CNT_W-1:0] BASE = CNT_W'(CELL_IDX * rlpm_pkg::CELL_DEPTH);

	rlpm_pkg::entry_t rd_entry;
	rlpm_pkg::cand_t  acc_q;
	logic             wr_sel;
	logic             rd_s1;
	logic [CAW-1:0]   row_s1;
	logic             row_valid;
	logic             hit;

	assign wr_sel = ctl.wr_en && (wr_idx[CNT_W-1:CAW] == BASE[CNT_W-1:CAW]);

	rlpm_ram #(
		.WIDTH($bits(rlpm_pkg::entry_t)),
		.DEPTH(rlpm_pkg::CELL_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_sel),
		.waddr(wr_idx[CAW-1:0]),
		.wdata(wr_entry),
		.raddr(ctl.rd_row),
		.rdata(rd_entry)
	);

	assign row_valid = (BASE + CNT_W'(row_s1)) < count;
	assign hit = rd_s1 && row_valid && ((addr & rd_entry.mask) == rd_entry.prefix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1  <= 1'b0;
			row_s1 <= '0;
			acc_q  <= '0;
		end else begin
			rd_s1  <= ctl.rd_en;
			row_s1 <= ctl.rd_row;
			if (ctl.acc_clr) begin
				acc_q <= '0;
			end else if (hit && (!acc_q.found || rd_entry.len > acc_q.len)) begin
				acc_q <= '{found: 1'b1, len: rd_entry.len, hop: rd_entry.hop,
					port: rd_entry.port, mask: rd_entry.mask};
			end else if (ctl.reduce && left.found
				&& (!acc_q.found || left.len >= acc_q.len)) begin
				acc_q <= left;
			end
		end
	end

	assign best = acc_q;

endmodule

// ===== rtl/core/route_longest_prefix_match_unit.sv =====
// ----------------------------------------------------------------------------
// route_longest_prefix_match_unit
// IPv4 longest prefix match route table with load, clear and lookup items.
//
// The table of TABLE_DEPTH routes is spread over a row of cells of 32 entries
// each (32 cells at the default depth), filled in load order. A lookup reads
// one row of every cell per cycle over all 32 rows, then lets the best route
// move one cell per cycle down the chain; the next item is only taken once
// the result has moved to the output register. Load, clear and unknown items
// go straight from idle to the done state. Ties between equal mask lengths
// go to the earliest loaded route. A finished result waits in the output
// register while the next item is already taken.
// ----------------------------------------------------------------------------
module route_longest_prefix_match_unit #(
	parameter int TABLE_DEPTH = rlpm_pkg::TABLE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rlpm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rlpm_pkg::rsp_t rsp
);

	localparam int CAW       = rlpm_pkg::CELL_ADDR_W;
	localparam int NUM_CELLS = (TABLE_DEPTH + rlpm_pkg::CELL_DEPTH - 1) / rlpm_pkg::CELL_DEPTH;
	localparam int CNT_W     = ($clog2(TABLE_DEPTH + 1) > CAW) ? $clog2(TABLE_DEPTH + 1)
		: CAW + 1;
	localparam int RED_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(TABLE_DEPTH);
	localparam logic [RED_W-1:0] RED_LAST = RED_W'((NUM_CELLS > 1) ? NUM_CELLS - 2 : 0);
	localparam logic [CAW-1:0]   ROW_LAST = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_REDUCE,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CAW-1:0]   row_q;
	logic [RED_W-1:0] red_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      addr_q;
	logic             is_lookup_q;
	rlpm_pkg::rsp_t   res_q;
	rlpm_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic             load_ok;
	rlpm_pkg::entry_t wr_entry;
	rlpm_pkg::ctl_t   ctl;
	rlpm_pkg::cand_t  chain [NUM_CELLS+1];
	rlpm_pkg::cand_t  best;
	rlpm_pkg::rsp_t   lk_rsp;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_ok   = accept && (req.cmd == rlpm_pkg::CMD_LOAD) && (count_q < DEPTH_C);

	assign wr_entry = '{prefix: req.route_prefix, mask: req.route_mask,
		hop: req.route_gateway, port: req.route_port,
		len: rlpm_pkg::mask_len(req.route_mask)};

	assign ctl = '{wr_en: load_ok, rd_en: (state_q == S_SCAN), rd_row: row_q,
		acc_clr: accept && (req.cmd == rlpm_pkg::CMD_LOOKUP),
		reduce: (state_q == S_REDUCE)};

	assign chain[0] = '0;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		rlpm_cell #(
			.CNT_W   (CNT_W),
			.CELL_IDX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_idx  (count_q),
			.wr_entry(wr_entry),
			.count   (count_q),
			.addr    (addr_q),
			.left    (chain[g]),
			.best    (chain[g+1])
		);
	end

	assign best = chain[NUM_CELLS];

	always_comb begin
		lk_rsp = '0;
		if (best.found) begin
			lk_rsp.status     = rlpm_pkg::STAT_HIT;
			lk_rsp.gateway    = best.hop;
			lk_rsp.out_port   = best.port;
			lk_rsp.match_mask = best.mask;
		end else begin
			lk_rsp.status = rlpm_pkg::STAT_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			red_q       <= '0;
			count_q     <= '0;
			addr_q      <= '0;
			is_lookup_q <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						is_lookup_q <= 1'b0;
						res_q       <= '{status: rlpm_pkg::STAT_MISS, gateway: '0,
							out_port: '0, match_mask: '0};
						state_q     <= S_DONE;
						case (req.cmd)
							rlpm_pkg::CMD_LOOKUP: begin
								addr_q      <= req.lookup_address;
								is_lookup_q <= 1'b1;
								row_q       <= '0;
								state_q     <= S_SCAN;
							end
							rlpm_pkg::CMD_LOAD: begin
								if (count_q < DEPTH_C) begin
									count_q      <= count_q + CNT_W'(1);
									res_q.status <= rlpm_pkg::STAT_LOADED;
								end else begin
									res_q.status <= rlpm_pkg::STAT_FULL;
								end
							end
							rlpm_pkg::CMD_CLEAR: begin
								count_q      <= '0;
								res_q.status <= rlpm_pkg::STAT_CLEARED;
							end
							default: begin
								res_q.status <= rlpm_pkg::STAT_MISS;
							end
						endcase
					end
				end
				S_SCAN: begin
					row_q <= row_q + CAW'(1);
					if (row_q == ROW_LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					red_q   <= '0;
					state_q <= (NUM_CELLS > 1) ? S_REDUCE : S_DONE;
				end
				S_REDUCE: begin
					red_q <= red_q + RED_W'(1);
					if (red_q == RED_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= is_lookup_q ? lk_rsp : res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("route count beyond table depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == rlpm_pkg::CMD_CLEAR) |=> (count_q == '0))
		else $error("clear item did not empty the table");

	a_load_counts: assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("load item did not advance the route count");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result shown outside the done state");

	a_scan_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && row_q == ROW_LAST) |=> (state_q == S_DRAIN))
		else $error("scan did not end after the last row");
`endif

endmodule
